// ----- hdl/vhs_pkg.sv -----
// Shared types and constants for the velocity heading sector block.
package vhs_pkg;

    // Operand and result widths
    localparam int C_VEL_W    = 16;
    localparam int C_SECTOR_W = 6;
    localparam int C_CNT_W    = 4;

    // Ratio constants are 47-bit fixed point (scale 10^14), split for partial products
    localparam int C_K_W      = 47;
    localparam int C_LO_W     = 24;
    localparam int C_HI_W     = C_K_W - C_LO_W;
    localparam int C_PP_LO_W  = C_VEL_W + C_LO_W;
    localparam int C_PP_HI_W  = C_VEL_W + C_HI_W;
    localparam int C_PROD_W   = C_VEL_W + C_K_W;
    localparam int C_NUM_K    = 5;
    localparam int C_NUM_TAN  = 4;
    localparam int C_NUM_FLAG = 2 * C_NUM_TAN + 1;

    // Index 0 is the scale, 1..4 are tan 9, 18, 27, 36 degrees
    localparam logic [C_NUM_K-1:0][C_K_W-1:0] C_RATIO_K = {
        47'd72654252800536,
        47'd50952544949443,
        47'd32491969623291,
        47'd15838444032454,
        47'd100000000000000
    };

    // Quadrant base sectors
    localparam logic [C_SECTOR_W-1:0] C_BASE_UP    = 6'd0;
    localparam logic [C_SECTOR_W-1:0] C_BASE_RIGHT = 6'd10;
    localparam logic [C_SECTOR_W-1:0] C_BASE_DOWN  = 6'd20;
    localparam logic [C_SECTOR_W-1:0] C_BASE_LEFT  = 6'd30;
    localparam logic [C_SECTOR_W-1:0] C_LAST_SECTOR = 6'd39;

    // Side information that travels with each beat
    typedef struct packed {
        logic [C_SECTOR_W-1:0] base;
        logic                  fixed;   // axis case: sector is the base alone
    } t_tag;

endpackage

// ----- hdl/vhs_sector_pipe.sv -----
// Pipelined fixed-point tangent comparison that yields the sector inside a quadrant.
module vhs_sector_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  vhs_pkg::t_tag                 i_tag,
    input  logic [vhs_pkg::C_VEL_W-1:0]    i_num,
    input  logic [vhs_pkg::C_VEL_W-1:0]    i_den,
    output logic                          o_valid,
    output logic [vhs_pkg::C_SECTOR_W-1:0] o_sector
);
    import vhs_pkg::*;

    // Stage 1: operands
    logic                 r1_valid;
    t_tag                 r1_tag;
    logic [C_VEL_W-1:0]   r1_num;
    logic [C_VEL_W-1:0]   r1_den;

    // Stage 2: partial products against every constant
    logic                 r2_valid;
    t_tag                 r2_tag;
    logic                 r2_gt;
    logic [C_PP_LO_W-1:0] r2_num_lo [C_NUM_K];
    logic [C_PP_HI_W-1:0] r2_num_hi [C_NUM_K];
    logic [C_PP_LO_W-1:0] r2_den_lo [C_NUM_K];
    logic [C_PP_HI_W-1:0] r2_den_hi [C_NUM_K];
    logic [C_PP_LO_W-1:0] n_num_lo  [C_NUM_K];
    logic [C_PP_HI_W-1:0] n_num_hi  [C_NUM_K];
    logic [C_PP_LO_W-1:0] n_den_lo  [C_NUM_K];
    logic [C_PP_HI_W-1:0] n_den_hi  [C_NUM_K];

    // Stage 3: full products
    logic                 r3_valid;
    t_tag                 r3_tag;
    logic                 r3_gt;
    logic [C_PROD_W-1:0]  r3_num_p [C_NUM_K];
    logic [C_PROD_W-1:0]  r3_den_p [C_NUM_K];
    logic [C_PROD_W-1:0]  n_num_p  [C_NUM_K];
    logic [C_PROD_W-1:0]  n_den_p  [C_NUM_K];

    // Stage 4: comparison flags
    logic                  r4_valid;
    t_tag                  r4_tag;
    logic [C_NUM_FLAG-1:0] r4_flags;
    logic [C_NUM_FLAG-1:0] n_flags;

    // Stage 5: result
    logic                  r5_valid;
    logic [C_SECTOR_W-1:0] r5_sector;
    logic [C_SECTOR_W-1:0] n_sector;
    logic [C_CNT_W-1:0]    n_cnt;

    // Partial products: constant halves times each operand
    always_comb begin
        for (int k = 0; k < C_NUM_K; k++) begin
            n_num_lo[k] = C_PP_LO_W'(r1_num) * C_PP_LO_W'(C_RATIO_K[k][C_LO_W-1:0]);
            n_num_hi[k] = C_PP_HI_W'(r1_num) * C_PP_HI_W'(C_RATIO_K[k][C_K_W-1:C_LO_W]);
            n_den_lo[k] = C_PP_LO_W'(r1_den) * C_PP_LO_W'(C_RATIO_K[k][C_LO_W-1:0]);
            n_den_hi[k] = C_PP_HI_W'(r1_den) * C_PP_HI_W'(C_RATIO_K[k][C_K_W-1:C_LO_W]);
        end
    end

    // Recombine halves into full products
    always_comb begin
        for (int k = 0; k < C_NUM_K; k++) begin
            n_num_p[k] = {r2_num_hi[k], {C_LO_W{1'b0}}}
                       + {{(C_PROD_W-C_PP_LO_W){1'b0}}, r2_num_lo[k]};
            n_den_p[k] = {r2_den_hi[k], {C_LO_W{1'b0}}}
                       + {{(C_PROD_W-C_PP_LO_W){1'b0}}, r2_den_lo[k]};
        end
    end

    // Boundary tests: below 45 deg n*S > d*tan, above 45 deg n*tan > d*S
    always_comb begin
        for (int k = 0; k < C_NUM_TAN; k++) begin
            n_flags[k]             = r3_num_p[0] > r3_den_p[k+1];
            n_flags[C_NUM_TAN + k] = r3_num_p[k+1] > r3_den_p[0];
        end
        n_flags[C_NUM_FLAG-1] = r3_gt;
    end

    // Count passed boundaries and add the quadrant base
    always_comb begin
        n_cnt = '0;
        for (int i = 0; i < C_NUM_FLAG; i++) begin
            n_cnt = n_cnt + C_CNT_W'(r4_flags[i]);
        end
        n_sector = r4_tag.fixed ? r4_tag.base : r4_tag.base + C_SECTOR_W'(n_cnt);
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    // Data stages
    always_ff @(posedge i_clk) begin
        r1_tag    <= i_tag;
        r1_num    <= i_num;
        r1_den    <= i_den;
        r2_tag    <= r1_tag;
        r2_gt     <= r1_num > r1_den;
        r2_num_lo <= n_num_lo;
        r2_num_hi <= n_num_hi;
        r2_den_lo <= n_den_lo;
        r2_den_hi <= n_den_hi;
        r3_tag    <= r2_tag;
        r3_gt     <= r2_gt;
        r3_num_p  <= n_num_p;
        r3_den_p  <= n_den_p;
        r4_tag    <= r3_tag;
        r4_flags  <= n_flags;
        r5_sector <= n_sector;
    end

    assign o_valid  = r5_valid;
    assign o_sector = r5_sector;

endmodule

// ----- hdl/velocity_heading_sector.sv -----
// Top level of the velocity heading sector block.
//
// Usage:
//   Input: drive i_x_velocity / i_y_velocity and raise start. A beat is
//   taken at every rising edge where start is high and busy is low. busy
//   is always low: the pipeline takes one beat every cycle.
//   Output: o_valid is high for exactly one cycle with o_heading_sector,
//   the heading clockwise from screen-up in 9-degree sectors (0..39).
//   The result is registered through a six-register chain (input, operand
//   select, partial products, product sum, boundary compare, sector add).
//   Throughput: one beat per cycle, with no stall anywhere in the chain.
//   Each beat yields exactly one result, in order.
//   Reset (synchronous, active low) clears all valid bits; beats in flight
//   are dropped. The receiver cannot stall; results are never held back.
module velocity_heading_sector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [vhs_pkg::C_VEL_W-1:0]    i_x_velocity,
    input  logic signed [vhs_pkg::C_VEL_W-1:0]    i_y_velocity,
    output logic                                 o_valid,
    output logic        [vhs_pkg::C_SECTOR_W-1:0] o_heading_sector
);
    import vhs_pkg::*;

    logic                 r0_valid;
    logic [C_VEL_W-1:0]   r0_x;
    logic [C_VEL_W-1:0]   r0_y;

    logic [C_VEL_W-1:0]   n_ax;
    logic [C_VEL_W-1:0]   n_ay;
    logic [C_VEL_W-1:0]   n_num;
    logic [C_VEL_W-1:0]   n_den;
    t_tag                 n_tag;
    logic                 x_zero;
    logic                 y_zero;
    logic                 x_neg;
    logic                 y_up;

    assign busy = 1'b0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_x <= i_x_velocity;
        r0_y <= i_y_velocity;
    end

    // Magnitudes; -32768 maps to 32768 in unsigned 16 bits
    always_comb begin
        n_ax   = r0_x[C_VEL_W-1] ? (~r0_x + 1'b1) : r0_x;
        n_ay   = r0_y[C_VEL_W-1] ? (~r0_y + 1'b1) : r0_y;
        x_zero = (r0_x == '0);
        y_zero = (r0_y == '0);
        x_neg  = r0_x[C_VEL_W-1];
        y_up   = r0_y[C_VEL_W-1];   // screen y negative means pointing up
    end

    // Quadrant select and axis cases
    always_comb begin
        n_tag.fixed = 1'b0;
        n_tag.base  = C_BASE_UP;
        n_num       = n_ax;
        n_den       = n_ay;
        if (x_zero) begin
            n_tag.fixed = 1'b1;
            n_tag.base  = (y_up || y_zero) ? C_BASE_UP : C_BASE_DOWN;
        end else if (y_zero) begin
            n_tag.fixed = 1'b1;
            n_tag.base  = x_neg ? C_BASE_LEFT : C_BASE_RIGHT;
        end else if (!x_neg && y_up) begin
            n_tag.base = C_BASE_UP;
        end else if (!x_neg) begin
            n_tag.base = C_BASE_RIGHT;
            n_num      = n_ay;
            n_den      = n_ax;
        end else if (!y_up) begin
            n_tag.base = C_BASE_DOWN;
        end else begin
            n_tag.base = C_BASE_LEFT;
            n_num      = n_ay;
            n_den      = n_ax;
        end
    end

    vhs_sector_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r0_valid),
        .i_tag    (n_tag),
        .i_num    (n_num),
        .i_den    (n_den),
        .o_valid  (o_valid),
        .o_sector (o_heading_sector)
    );

    // Every accepted beat gives one result, and nothing else does
    a_latency_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##6 o_valid)
        else $error("accepted beat produced no result");

    a_latency_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##6 !o_valid)
        else $error("result without an accepted beat");

    // Results stay in the sector range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_heading_sector <= C_LAST_SECTOR)
        else $error("sector out of range");

    // Exact diagonal with x == screen y falls to the lower sector
    a_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_x_velocity == i_y_velocity && i_x_velocity != 0
        |-> ##6 (o_heading_sector == 6'd14 || o_heading_sector == 6'd34))
        else $error("diagonal sector mismatch");

endmodule

// ----- tb/sv/vhs_sector_checker.sv -----
// Checker for the velocity heading sector block: predicts each beat's sector and compares.
`timescale 1ns / 100ps

module vhs_sector_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  logic signed [vhs_pkg::C_VEL_W-1:0]    i_x_velocity,
    input  logic signed [vhs_pkg::C_VEL_W-1:0]    i_y_velocity,
    input  logic                                 i_valid,
    input  logic        [vhs_pkg::C_SECTOR_W-1:0] i_heading_sector,
    output int                                   o_pending,
    output int                                   o_checked,
    output int                                   o_errors
);
    import vhs_pkg::*;

    // Tangents of 9, 18, 27 and 36 degrees scaled by 10^14; index 0 is 9 degrees
    localparam logic [63:0] C_TAN_ONE = 64'd100000000000000;
    localparam logic [3:0][63:0] C_TAN_TAB = {
        64'd72654252800536,
        64'd50952544949443,
        64'd32491969623291,
        64'd15838444032454
    };

    typedef struct {
        logic signed [C_VEL_W-1:0]    x;
        logic signed [C_VEL_W-1:0]    y;
        logic        [C_SECTOR_W-1:0] sector;
    } t_heading_exp;

    t_heading_exp heading_q[$];
    t_heading_exp oldest;
    int           mismatches = 0;
    int           compared   = 0;

    assign o_errors  = mismatches;
    assign o_checked = compared;

    // Number of 9-degree edges that the angle atan(n/d) lies strictly past,
    // with the 45-degree edge counted only when n > d
    function automatic int unsigned edges_passed(input logic [63:0] n, input logic [63:0] d);
        int unsigned cnt;
        cnt = 0;
        for (int k = 0; k < 4; k++) begin
            if (n * C_TAN_ONE > C_TAN_TAB[k] * d)
                cnt++;
        end
        if (n > d)
            cnt++;
        for (int k = 0; k < 4; k++) begin
            if (n * C_TAN_TAB[3-k] > d * C_TAN_ONE)
                cnt++;
        end
        return cnt;
    endfunction

    // Heading sector clockwise from screen-up; y is flipped to point up
    function automatic logic [C_SECTOR_W-1:0] heading_of(input logic signed [C_VEL_W-1:0] xv,
                                                         input logic signed [C_VEL_W-1:0] yv);
        int          sx;
        int          sy;
        logic [63:0] ax;
        logic [63:0] ay;
        sx = xv;
        sy = -int'(yv);
        ax = 64'((sx < 0) ? -sx : sx);
        ay = 64'((sy < 0) ? -sy : sy);
        if (sx == 0)
            return (sy >= 0) ? C_BASE_UP : C_BASE_DOWN;
        if (sy == 0)
            return (sx > 0) ? C_BASE_RIGHT : C_BASE_LEFT;
        if (sx > 0 && sy > 0)
            return C_BASE_UP + C_SECTOR_W'(edges_passed(ax, ay));
        if (sx > 0)
            return C_BASE_RIGHT + C_SECTOR_W'(edges_passed(ay, ax));
        if (sy < 0)
            return C_BASE_DOWN + C_SECTOR_W'(edges_passed(ax, ay));
        return C_BASE_LEFT + C_SECTOR_W'(edges_passed(ay, ax));
    endfunction

    // Results first (they belong to older beats), then queue the new beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid) begin
                compared++;
                if (heading_q.size() == 0) begin
                    $display("%0t: sector %0d with no beat outstanding, expected none",
                             $time, i_heading_sector);
                    mismatches++;
                end else begin
                    oldest = heading_q.pop_front();
                    if (oldest.sector !== i_heading_sector) begin
                        $display("%0t: x=%0d y=%0d expected sector %0d, actual %0d",
                                 $time, oldest.x, oldest.y, oldest.sector, i_heading_sector);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy)
                heading_q.push_back('{i_x_velocity, i_y_velocity,
                                      heading_of(i_x_velocity, i_y_velocity)});
        end
        o_pending <= heading_q.size();
    end

endmodule

// ----- tb/sv/tb_velocity_heading_sector.sv -----
// Testbench top for the velocity heading sector block: stimulus, timeout and verdict.
`timescale 1ns / 100ps

module tb_velocity_heading_sector;
    import vhs_pkg::*;

    localparam int C_RANDOM_BEATS = 1030;

    // Sector edges as tangent ratios in parts per million, index 0 is 9 degrees
    localparam logic [3:0][31:0] C_EDGE_PPM = {32'd726543, 32'd509525, 32'd324920, 32'd158384};

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start   = 1'b0;
    logic                         busy;
    logic signed [C_VEL_W-1:0]    i_x_velocity = '0;
    logic signed [C_VEL_W-1:0]    i_y_velocity = '0;
    logic                         o_valid;
    logic        [C_SECTOR_W-1:0] o_heading_sector;
    int                           pending;
    int                           checked;
    int                           errors;
    int                           vectors_sent = 0;

    always #5 i_clk = ~i_clk;

    velocity_heading_sector u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_x_velocity     (i_x_velocity),
        .i_y_velocity     (i_y_velocity),
        .o_valid          (o_valid),
        .o_heading_sector (o_heading_sector)
    );

    vhs_sector_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_x_velocity     (i_x_velocity),
        .i_y_velocity     (i_y_velocity),
        .i_valid          (o_valid),
        .i_heading_sector (o_heading_sector),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_errors         (errors)
    );

    // One velocity beat; returns at the edge that takes it
    task automatic issue_vector(input logic signed [C_VEL_W-1:0] xv,
                                input logic signed [C_VEL_W-1:0] yv,
                                input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_x_velocity <= xv;
        i_y_velocity <= yv;
        do @(posedge i_clk); while (busy);
        vectors_sent++;
    endtask

    initial begin
        int                        kind;
        int                        mag_a;
        int                        mag_b;
        int                        d;
        int                        k;
        bit                        burst;
        logic signed [C_VEL_W-1:0] xv;
        logic signed [C_VEL_W-1:0] yv;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero vector and the four axes, small and full scale
        issue_vector(16'sd0, 16'sd0, 1'b0);
        issue_vector(16'sd0, -16'sd1, 1'b0);
        issue_vector(16'sd0, 16'sd1, 1'b0);
        issue_vector(16'sd1, 16'sd0, 1'b1);
        issue_vector(-16'sd1, 16'sd0, 1'b1);
        issue_vector(16'sd0, -16'sd32768, 1'b0);
        issue_vector(16'sd0, 16'sd32767, 1'b0);
        issue_vector(16'sd32767, 16'sd0, 1'b0);
        issue_vector(-16'sd32768, 16'sd0, 1'b1);
        // Exact diagonals in all four quadrants
        issue_vector(16'sd7, -16'sd7, 1'b1);
        issue_vector(16'sd7, 16'sd7, 1'b1);
        issue_vector(-16'sd7, 16'sd7, 1'b0);
        issue_vector(-16'sd7, -16'sd7, 1'b0);
        // Corners, including the most negative y
        issue_vector(16'sd32767, -16'sd32768, 1'b0);
        issue_vector(-16'sd32768, -16'sd32768, 1'b1);
        issue_vector(-16'sd32768, 16'sd32767, 1'b0);
        issue_vector(16'sd32767, 16'sd32767, 1'b1);
        // Either side of the 9-degree edge, and almost on an axis
        issue_vector(16'sd1584, -16'sd10000, 1'b0);
        issue_vector(16'sd1583, -16'sd10000, 1'b0);
        issue_vector(16'sd1, -16'sd32767, 1'b1);
        issue_vector(16'sd32767, -16'sd1, 1'b0);

        // Random mix: full range, tiny vectors, near-diagonals, near sector edges
        burst = 1'b0;
        for (int i = 0; i < C_RANDOM_BEATS; i++) begin
            if (i % 50 == 0)
                burst = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                xv = C_VEL_W'($urandom);
                yv = C_VEL_W'($urandom);
            end else if (kind < 5) begin
                mag_a = $urandom_range(0, 16);
                mag_b = $urandom_range(0, 16);
                xv = C_VEL_W'(mag_a - 8);
                yv = C_VEL_W'(mag_b - 8);
            end else begin
                if (kind < 7) begin
                    mag_a = $urandom_range(1, 32768);
                    mag_b = mag_a + int'($urandom_range(0, 2)) - 1;
                end else begin
                    d     = $urandom_range(1, 32767);
                    k     = $urandom_range(0, 3);
                    mag_b = d;
                    mag_a = int'((64'(d) * 64'(C_EDGE_PPM[k])) / 64'd1000000)
                            + int'($urandom_range(0, 2)) - 1;
                end
                if (mag_a < 0) mag_a = 0;
                if (mag_b > 32768) mag_b = 32768;
                if ($urandom_range(0, 1)) begin
                    d     = mag_a;
                    mag_a = mag_b;
                    mag_b = d;
                end
                xv = $urandom_range(0, 1) ? C_VEL_W'(-mag_a) : C_VEL_W'(mag_a);
                yv = $urandom_range(0, 1) ? C_VEL_W'(-mag_b) : C_VEL_W'(mag_b);
            end
            issue_vector(xv, yv, burst);
        end
        start <= 1'b0;

        // Drain, then allow the pipeline depth for stray results
        do @(negedge i_clk); while (pending != 0);
        repeat (10) @(negedge i_clk);

        $display("Drove %0d velocity vectors (axes, diagonals, corners, sector edges, random);",
                 vectors_sent);
        $display("compared %0d heading sectors, %0d mismatches", checked, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("Timeout with %0d sectors still outstanding", pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- velocity_heading_sector.f -----
hdl/vhs_pkg.sv
hdl/vhs_sector_pipe.sv
hdl/velocity_heading_sector.sv
tb/sv/vhs_sector_checker.sv
tb/sv/tb_velocity_heading_sector.sv
